>>> rtl/apex_vector_angle_defines.svh
// assertion macros for the apex vector angle block
// no dependencies; taken in by the modules that carry assertions
`ifndef APEX_VECTOR_ANGLE_DEFINES_SVH
`define APEX_VECTOR_ANGLE_DEFINES_SVH
`ifndef SYNTHESIS
`define AVA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AVA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AVA_ASSERT(lbl, clk, rst_n, prop, msg)
`define AVA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/ava_pkg.sv
// shared types and constants for the apex vector angle block
// no dependencies
package ava_pkg;

	localparam int DIFF_W = 17;          // scaled coordinate difference, signed
	localparam int PROD_W = 2 * DIFF_W;  // one product
	localparam int XW     = 42;          // cordic x/y lane
	localparam int ZW     = 34;          // cordic angle lane, pi/2^31 units
	localparam int QW     = 40;          // scaled dot magnitude
	localparam int ATAN_W = 30;

	typedef logic signed [XW-1:0] lane_t;
	typedef logic signed [ZW-1:0] ang_t;
	typedef logic [QW-1:0]        mag_t;

	// atan(2^-i) in pi/2^31 units, rounded to nearest
	localparam logic [ATAN_W-1:0] ATAN_TAB [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81,
		30'd41, 30'd20, 30'd10, 30'd5,
		30'd3, 30'd1, 30'd1, 30'd0
	};

	typedef struct packed {
		logic kill;   // answer is forced to zero
		logic pneg;   // dot product negative
	} flags_t;

endpackage

>>> rtl/ava_cordic_cell.sv
// one vectoring cordic iteration with a fixed shift, registered
// depends on ava_pkg
module ava_cordic_cell #(
	parameter int SHIFT = 0,
	parameter int SB_W  = 1
) (
	input  logic                 clk,
	input  logic                 en,
	input  ava_pkg::lane_t       x_in,
	input  ava_pkg::lane_t       y_in,
	input  ava_pkg::ang_t        z_in,
	input  logic [SB_W-1:0]      sb_in,
	output ava_pkg::lane_t       x_out,
	output ava_pkg::lane_t       y_out,
	output ava_pkg::ang_t        z_out,
	output logic [SB_W-1:0]      sb_out
);

	ava_pkg::lane_t dx, dy;
	ava_pkg::ang_t  at;
	ava_pkg::lane_t x_q, y_q;
	ava_pkg::ang_t  z_q;
	logic [SB_W-1:0] sb_q;

	assign dx = y_in >>> SHIFT;
	assign dy = x_in >>> SHIFT;
	assign at = ava_pkg::ang_t'(ava_pkg::ATAN_TAB[SHIFT]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[ava_pkg::XW-1]) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + at;
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - at;
			end
			sb_q <= sb_in;
		end
	end

	assign x_out  = x_q;
	assign y_out  = y_q;
	assign z_out  = z_q;
	assign sb_out = sb_q;

endmodule

>>> rtl/ava_scale_cell.sv
// one step of the gain shift-add on the dot magnitude, registered
// depends on ava_pkg
module ava_scale_cell #(
	parameter int SHIFT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  ava_pkg::mag_t q_in,
	output ava_pkg::mag_t q_out
);

	ava_pkg::mag_t q_q;

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= q_in + (q_in >> (2 * SHIFT));
		end
	end

	assign q_out = q_q;

endmodule

>>> rtl/ava_front.sv
// differences, products and sums: three registered stages ahead of the cordic rows
// depends on ava_pkg
module ava_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] apex_x,
	input  logic signed [COORD_BITS-1:0] apex_y,
	input  logic signed [COORD_BITS-1:0] apex_z,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	output ava_pkg::lane_t               cx_abs,
	output ava_pkg::lane_t               cy,
	output ava_pkg::lane_t               cz_abs,
	output ava_pkg::mag_t                pabs,
	output ava_pkg::flags_t              flags
);

	localparam int DW  = ava_pkg::DIFF_W;
	localparam int PW  = ava_pkg::PROD_W;
	localparam int XW  = ava_pkg::XW;
	localparam int QW  = ava_pkg::QW;
	localparam int SHR = (COORD_BITS > 16) ? COORD_BITS - 16 : 0;

	function automatic logic signed [DW-1:0] sdiff(
		input logic signed [COORD_BITS-1:0] t,
		input logic signed [COORD_BITS-1:0] f
	);
		logic signed [COORD_BITS:0]   d;
		logic [COORD_BITS:0]          u;
		logic signed [COORD_BITS+1:0] s;
		d = {t[COORD_BITS-1], t} - {f[COORD_BITS-1], f};
		u = d[COORD_BITS] ? -d : d;
		u = u >> SHR;
		s = d[COORD_BITS] ? -$signed({1'b0, u}) : $signed({1'b0, u});
		return DW'(s);
	endfunction

	// stage 1: scaled differences
	logic signed [DW-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= sdiff(first_x, apex_x);
			ay_s1 <= sdiff(first_y, apex_y);
			az_s1 <= sdiff(first_z, apex_z);
			bx_s1 <= sdiff(second_x, apex_x);
			by_s1 <= sdiff(second_y, apex_y);
			bz_s1 <= sdiff(second_z, apex_z);
		end
	end

	// stage 2: products
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, d0_s2, d1_s2, d2_s2;
	logic                 zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2   <= ay_s1 * bz_s1;
			p1_s2   <= az_s1 * by_s1;
			p2_s2   <= az_s1 * bx_s1;
			p3_s2   <= ax_s1 * bz_s1;
			p4_s2   <= ax_s1 * by_s1;
			p5_s2   <= ay_s1 * bx_s1;
			d0_s2   <= ax_s1 * bx_s1;
			d1_s2   <= ay_s1 * by_s1;
			d2_s2   <= az_s1 * bz_s1;
			zero_s2 <= (ax_s1 == '0 && ay_s1 == '0 && az_s1 == '0)
				|| (bx_s1 == '0 && by_s1 == '0 && bz_s1 == '0);
		end
	end

	// stage 3: cross and dot, magnitudes
	logic signed [PW:0]   cxw, cyw, czw;
	logic signed [PW+1:0] pw;
	ava_pkg::lane_t       cx_abs_s3, cy_s3, cz_abs_s3;
	ava_pkg::mag_t        pabs_s3;
	ava_pkg::flags_t      flags_s3;

	always_comb begin
		cxw = (PW+1)'(p0_s2) - (PW+1)'(p1_s2);
		cyw = (PW+1)'(p2_s2) - (PW+1)'(p3_s2);
		czw = (PW+1)'(p4_s2) - (PW+1)'(p5_s2);
		pw  = (PW+2)'(d0_s2) + (PW+2)'(d1_s2) + (PW+2)'(d2_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_abs_s3      <= XW'(cxw[PW] ? -cxw : cxw);
			cy_s3          <= XW'(cyw);
			cz_abs_s3      <= XW'(czw[PW] ? -czw : czw);
			pabs_s3        <= QW'(pw[PW+1] ? -pw : pw);
			flags_s3.kill  <= zero_s2;
			flags_s3.pneg  <= pw[PW+1];
		end
	end

	assign cx_abs = cx_abs_s3;
	assign cy     = cy_s3;
	assign cz_abs = cz_abs_s3;
	assign pabs   = pabs_s3;
	assign flags  = flags_s3;

endmodule

>>> rtl/apex_vector_angle.sv
// apex vector angle: angle between two vectors that share an apex point
// depends on ava_pkg, ava_front, ava_cordic_cell, ava_scale_cell and the defines header
//
// Takes an apex and two points as signed millimetre coordinates, forms the two
// vectors from the apex, their cross and dot products, and answers the angle
// atan2(|cross|, dot) in units of pi/32768 (0 to 32768). A zero vector answers 0.
// One word is accepted every cycle while in_stall is low. With N being
// min(CORDIC_STAGES, 32), the pipeline has three front stages (differences, products, sums),
// three rows of N cordic cells (cross x/y magnitude with cross z alongside,
// full cross magnitude, then the atan2 pass), and the output register.
// The whole pipeline moves as one; it stands still only while a finished word
// waits at the output under stall, and in_stall is raised for exactly that case.
`include "apex_vector_angle_defines.svh"
module apex_vector_angle #(
	parameter int COORD_BITS    = 16,
	parameter int CORDIC_STAGES = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] apex_x,
	input  logic signed [COORD_BITS-1:0] apex_y,
	input  logic signed [COORD_BITS-1:0] apex_z,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [15:0]                  angle
);

	localparam int N  = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam int L  = 3 + 3 * N;   // pipeline depth ahead of the output register
	localparam int QW = ava_pkg::QW;
	localparam int ZW = ava_pkg::ZW;

	// whole pipe advances unless the output word is held
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// valid chain alongside the datapath
	logic vld_q [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < L; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < L; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// front stages
	ava_pkg::lane_t  cx_abs, cy, cz_abs;
	ava_pkg::mag_t   pabs;
	ava_pkg::flags_t flags;

	ava_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.en       (adv),
		.apex_x   (apex_x),
		.apex_y   (apex_y),
		.apex_z   (apex_z),
		.first_x  (first_x),
		.first_y  (first_y),
		.first_z  (first_z),
		.second_x (second_x),
		.second_y (second_y),
		.second_z (second_z),
		.cx_abs   (cx_abs),
		.cy       (cy),
		.cz_abs   (cz_abs),
		.pabs     (pabs),
		.flags    (flags)
	);

	// row one: |cx|,cy and |cz|,0 side by side, dot magnitude scaled alongside
	ava_pkg::lane_t a_x [N+1];
	ava_pkg::lane_t a_y [N+1];
	ava_pkg::lane_t b_x [N+1];
	ava_pkg::lane_t b_y [N+1];
	logic           a_sb [N+1];   // zero vector flag
	logic           b_sb [N+1];   // dot sign
	ava_pkg::mag_t  q_c [N+1];

	assign a_x[0]  = cx_abs;
	assign a_y[0]  = cy;
	assign b_x[0]  = cz_abs;
	assign b_y[0]  = '0;
	assign a_sb[0] = flags.kill;
	assign b_sb[0] = flags.pneg;
	assign q_c[0]  = pabs;

	// row two: full cross magnitude, carrying flags and scaled dot
	ava_pkg::lane_t    m_x [N+1];
	ava_pkg::lane_t    m_y [N+1];
	logic [QW+1:0]     m_sb [N+1];

	assign m_x[0]  = a_x[N];
	assign m_y[0]  = b_x[N];
	assign m_sb[0] = {a_sb[N], b_sb[N], q_c[N]};

	// row three: atan2 of cross magnitude over scaled dot
	ava_pkg::lane_t  t_x [N+1];
	ava_pkg::lane_t  t_y [N+1];
	ava_pkg::ang_t   t_z [N+1];
	ava_pkg::flags_t t_sb [N+1];
	ava_pkg::mag_t   q_in3;

	assign q_in3         = m_sb[N][QW-1:0];
	assign t_x[0]        = ava_pkg::lane_t'(q_in3);
	assign t_y[0]        = m_x[N];
	assign t_z[0]        = '0;
	assign t_sb[0].kill  = m_sb[N][QW+1]
		|| ((m_x[N][ava_pkg::XW-1] || m_x[N] == '0) && q_in3 == '0);
	assign t_sb[0].pneg  = m_sb[N][QW];

	for (genvar i = 0; i < N; i++) begin : g_cell
		ava_cordic_cell #(.SHIFT(i), .SB_W(1)) u_a (
			.clk (clk), .en (adv),
			.x_in (a_x[i]), .y_in (a_y[i]), .z_in ('0), .sb_in (a_sb[i]),
			.x_out (a_x[i+1]), .y_out (a_y[i+1]), .z_out (), .sb_out (a_sb[i+1])
		);
		ava_cordic_cell #(.SHIFT(i), .SB_W(1)) u_b (
			.clk (clk), .en (adv),
			.x_in (b_x[i]), .y_in (b_y[i]), .z_in ('0), .sb_in (b_sb[i]),
			.x_out (b_x[i+1]), .y_out (b_y[i+1]), .z_out (), .sb_out (b_sb[i+1])
		);
		ava_scale_cell #(.SHIFT(i)) u_q (
			.clk (clk), .en (adv), .q_in (q_c[i]), .q_out (q_c[i+1])
		);
		ava_cordic_cell #(.SHIFT(i), .SB_W(QW+2)) u_m (
			.clk (clk), .en (adv),
			.x_in (m_x[i]), .y_in (m_y[i]), .z_in ('0), .sb_in (m_sb[i]),
			.x_out (m_x[i+1]), .y_out (m_y[i+1]), .z_out (), .sb_out (m_sb[i+1])
		);
		ava_cordic_cell #(.SHIFT(i), .SB_W(2)) u_t (
			.clk (clk), .en (adv),
			.x_in (t_x[i]), .y_in (t_y[i]), .z_in (t_z[i]), .sb_in (t_sb[i]),
			.x_out (t_x[i+1]), .y_out (t_y[i+1]), .z_out (t_z[i+1]), .sb_out (t_sb[i+1])
		);
	end

	// clamp to 0..quarter turn, fold for a negative dot, round to pi/32768, zero on kill
	localparam ava_pkg::ang_t QUARTER = ava_pkg::ang_t'(64'd1 << 30);
	localparam ava_pkg::ang_t HALF    = ava_pkg::ang_t'(64'd1 << 31);
	localparam ava_pkg::ang_t RND     = ava_pkg::ang_t'(64'd1 << 15);

	ava_pkg::ang_t zc, zf, zr;
	logic [15:0]   ang_d;

	always_comb begin
		zc = t_z[N];
		if (zc[ZW-1]) begin
			zc = '0;
		end else if (zc > QUARTER) begin
			zc = QUARTER;
		end
		zf    = t_sb[N].pneg ? HALF - zc : zc;
		zr    = zf + RND;
		ang_d = t_sb[N].kill ? 16'd0 : zr[31:16];
	end

	logic        out_valid_q;
	logic [15:0] angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_q <= ang_d;
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;

	// checks
	`AVA_ASSERT(a_take, clk, arst_n, (in_valid && !in_stall) |=> vld_q[0], "accepted word not in pipe")
	`AVA_ASSERT(a_hold, clk, arst_n, (out_valid && out_stall) |=> $stable(vld_q[L-1]), "pipe moved while held")
	`AVA_ASSERT(a_kill, clk, arst_n, (vld_q[L-1] && t_sb[N].kill && adv) |=> (angle == 16'd0), "zero vector gave nonzero angle")
	`AVA_ASSERT_NEVER(a_range, clk, arst_n, out_valid && (angle > 16'd32768), "angle beyond half turn")

endmodule
